[hw/rtl/pls_pkg.sv]
// pls_pkg: shared constants, codes and types of the positional list store
// depends on nothing; imported by pls_cell, pls_chain and positional_list_store
package pls_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;

  // field widths of the request and result ports
  localparam int OP_W     = 3;
  localparam int FIELD_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // internal widths: cell index and element count
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INS_POS   = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_DEL_POS   = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_DUMP      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // what one cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_mode_t;

  // what the whole row does at the next edge
  typedef enum logic [1:0] {
    CHAIN_HOLD,
    CHAIN_INSERT,
    CHAIN_DELETE,
    CHAIN_ROTATE
  } chain_kind_t;

  typedef struct packed {
    chain_kind_t             kind;
    logic [IDX_W-1:0]        idx;
    logic [CNT_W-1:0]        cnt;
    logic [VALUE_WIDTH-1:0]  value;
  } chain_cmd_t;

endpackage

[hw/rtl/positional_list_store.sv]
// positional_list_store: ordered list held in a row of shifting cells
// depends on pls_pkg and pls_chain
//
// channel   direction  handshake            fields
// request   in         start & !busy        operation, value, position
// result    out        strobe (one cycle)   status, element, count, last
//
// insert and delete: the row shifts at the edge that takes the request, result strobed the cycle after
// the request; the next request may follow at once
// dump: the control enters DUMP, then gives one result per cycle, one per element, while the
// occupied cells rotate once round, leaving the order as it was; busy covers it
// rst is synchronous and clears the count and the control; cell contents are
// not cleared and only occupied cells are ever read
// the receiver cannot stall: every result is offered for exactly one cycle
module positional_list_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pls_pkg::OP_W-1:0]      operation,
  input  logic signed [pls_pkg::FIELD_W-1:0] value,
  input  logic [pls_pkg::POS_W-1:0]     position,
  output logic                          strobe,
  output logic [pls_pkg::STATUS_W-1:0]  status,
  output logic signed [pls_pkg::FIELD_W-1:0] element,
  output logic [pls_pkg::COUNT_W-1:0]   count,
  output logic                          last
);
  import pls_pkg::*;

  typedef enum logic {
    IDLE,
    DUMP
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] dcnt;
  status_t          st;
  logic             dump_go;
  logic             dump_end;
  logic             accept;
  chain_cmd_t       cmd;
  logic [VALUE_WIDTH-1:0] head;

  // positions widened by one bit so count + 1 never wraps
  logic [POS_W:0]   pos_w;
  logic [POS_W:0]   cnt_w;
  logic             full;
  logic             empty;

  assign busy     = (state == DUMP);
  assign accept   = start && !busy;
  assign pos_w    = {1'b0, position};
  assign cnt_w    = (POS_W + 1)'(cnt);
  assign full     = (cnt >= CNT_W'(CAPACITY));
  assign empty    = (cnt == '0);
  assign dump_end = (CNT_W'(dcnt + 1'b1) == cnt);

  // decode the request into a row command, status and new count
  always_comb begin
    cmd       = '{kind: CHAIN_HOLD, idx: '0, cnt: cnt, value: VALUE_WIDTH'(value)};
    st        = ST_OK;
    cnt_next  = cnt;
    dump_go   = 1'b0;
    if (state == DUMP) begin
      cmd.kind = CHAIN_ROTATE;
    end else if (accept) begin
      case (operation)
        OP_INS_POS: begin
          if (pos_w == '0 || pos_w > cnt_w + 1'b1) st = ST_BAD_POS;
          else if (full) st = ST_FULL;
          else begin
            cmd.kind = CHAIN_INSERT;
            cmd.idx  = IDX_W'(pos_w - 1'b1);
            cnt_next = cnt + 1'b1;
          end
        end
        OP_INS_FRONT, OP_INS_BACK: begin
          if (full) st = ST_FULL;
          else begin
            cmd.kind = CHAIN_INSERT;
            cmd.idx  = (operation == OP_INS_FRONT) ? '0 : IDX_W'(cnt);
            cnt_next = cnt + 1'b1;
          end
        end
        OP_DEL_POS: begin
          if (pos_w == '0 || pos_w > cnt_w) st = ST_BAD_POS;
          else begin
            cmd.kind = CHAIN_DELETE;
            cmd.idx  = IDX_W'(pos_w - 1'b1);
            cnt_next = cnt - 1'b1;
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (empty) st = ST_EMPTY;
          else begin
            cmd.kind = CHAIN_DELETE;
            cmd.idx  = (operation == OP_DEL_FRONT) ? '0 : IDX_W'(cnt - 1'b1);
            cnt_next = cnt - 1'b1;
          end
        end
        OP_DUMP: begin
          if (empty) st = ST_EMPTY;
          else dump_go = 1'b1;
        end
        default: st = ST_OK; // unused code: no change
      endcase
    end
  end

  pls_chain u_chain (
    .clk  (clk),
    .cmd  (cmd),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      cnt    <= '0;
      dcnt   <= '0;
      strobe <= 1'b0;
      status <= ST_OK;
      element <= '0;
      count  <= '0;
      last   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            cnt <= cnt_next;
            if (dump_go) begin
              // results are registered in the DUMP state, from the head of the row
              state <= DUMP;
              dcnt  <= '0;
            end else begin
              strobe  <= 1'b1;
              status  <= st;
              element <= '0;
              count   <= COUNT_W'(cnt_next);
              last    <= 1'b1;
            end
          end
        end
        DUMP: begin
          // head cell holds element dcnt; the row rotates by one meanwhile
          strobe  <= 1'b1;
          status  <= ST_OK;
          element <= FIELD_W'(signed'(head));
          count   <= COUNT_W'(cnt);
          last    <= dump_end;
          dcnt    <= dcnt + 1'b1;
          if (dump_end) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/pls_cell.sv]
// pls_cell: one storage cell of the list row
// depends on pls_pkg
module pls_cell (
  input  logic                            clk,
  input  pls_pkg::cell_mode_t             mode,
  input  logic [pls_pkg::VALUE_WIDTH-1:0] value,
  input  logic [pls_pkg::VALUE_WIDTH-1:0] left,
  input  logic [pls_pkg::VALUE_WIDTH-1:0] right,
  output logic [pls_pkg::VALUE_WIDTH-1:0] q
);
  import pls_pkg::*;

  always_ff @(posedge clk) begin
    case (mode)
      CELL_LOAD:       q <= value;
      CELL_FROM_LEFT:  q <= left;
      CELL_FROM_RIGHT: q <= right;
      default:         q <= q;
    endcase
  end

endmodule

[hw/rtl/pls_chain.sv]
// pls_chain: row of CAPACITY cells with per-cell shift control
// depends on pls_pkg and pls_cell
module pls_chain (
  input  logic                            clk,
  input  pls_pkg::chain_cmd_t             cmd,
  output logic [pls_pkg::VALUE_WIDTH-1:0] head
);
  import pls_pkg::*;

  logic [VALUE_WIDTH-1:0] q [CAPACITY];

  assign head = q[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_mode_t             mode;
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_mid
      assign left = q[i-1];
    end

    // last occupied cell wraps to the head while rotating
    if (i == CAPACITY - 1) begin : g_last
      assign right = q[0];
    end else begin : g_inner
      assign right = (cmd.kind == CHAIN_ROTATE && CNT_W'(i + 1) == cmd.cnt) ? q[0] : q[i+1];
    end

    always_comb begin
      mode = CELL_HOLD;
      case (cmd.kind)
        CHAIN_INSERT: begin
          if (IDX_W'(i) == cmd.idx) mode = CELL_LOAD;
          else if (IDX_W'(i) > cmd.idx) mode = CELL_FROM_LEFT;
        end
        CHAIN_DELETE: begin
          if (IDX_W'(i) >= cmd.idx) mode = CELL_FROM_RIGHT;
        end
        CHAIN_ROTATE: begin
          if (CNT_W'(i) < cmd.cnt) mode = CELL_FROM_RIGHT;
        end
        default: mode = CELL_HOLD;
      endcase
    end

    pls_cell u_cell (
      .clk   (clk),
      .mode  (mode),
      .value (cmd.value),
      .left  (left),
      .right (right),
      .q     (q[i])
    );
  end

endmodule
